@@ hdl/lpm_pkg.sv @@
// ----------------------------------------------------------------------------
// lpm_pkg: shared types and constants for the IPv4 longest-prefix-match block
// Holds the command codes, the lookup token that walks the cell chain, the
// load bus that writes one cell, and the mask rank function.
// ----------------------------------------------------------------------------
package lpm_pkg;

  // Command codes carried by the command field of an item.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Widths fixed by the item fields.
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PORT_W   = 4;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned RANK_W   = 6;
  // Slot numbers are wide enough to name 65536 cells.
  localparam int unsigned SLOT_W   = 16;
  // Width used to compare a slot number against a count or a load index.
  localparam int unsigned CMP_W    = SLOT_W + 1;

  // Lookup token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic              hit;
    logic [RANK_W-1:0] rank;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } token_t;

  // Write of one routing entry, broadcast to all cells.
  typedef struct packed {
    logic               we;
    logic [INDEX_W-1:0] index;
    logic [ADDR_W-1:0]  prefix;
    logic [ADDR_W-1:0]  mask;
    logic [ADDR_W-1:0]  hop;
    logic [PORT_W-1:0]  port;
    logic [RANK_W-1:0]  rank;
  } load_t;

  // Number of leading one bits of a mask. The highest zero bit decides it.
  function automatic logic [RANK_W-1:0] lead_ones(input logic [ADDR_W-1:0] m);
    logic [RANK_W-1:0] n;
    n = RANK_W'(ADDR_W);
    for (int i = 0; i < ADDR_W; i++) begin
      if (!m[i]) begin
        n = RANK_W'(ADDR_W - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

@@ hdl/ipv4_longest_prefix_match.sv @@
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_match: IPv4 routing table with longest-prefix lookup
// A row of cells, one per table entry, through which a lookup token walks.
// ----------------------------------------------------------------------------
// Usage. An item is accepted at a clock edge where start is high and busy is
// low. A load item (command low) writes one routing entry into the cell named
// by entry_index in that same edge and gives no result; an index at or above
// TABLE_DEPTH is ignored. A load never raises busy, so loads can be issued
// back to back, one per cycle, while no lookup holds busy high.
// A lookup item (command high) launches a token carrying dest_addr into the
// first cell. The token moves one cell per cycle; each cell below the
// active_entries count swaps in its entry when the masked destination equals
// its prefix and its mask is strictly longer than the best so far, so ties go
// to the lowest slot. The result appears once the token has passed through
// every cell, with done high for exactly one cycle. busy stays high until that
// cycle, and a new item may be accepted in the done cycle itself, so the length
// of the cell chain sets how long one lookup holds the block.
// With no match, found, hop_addr, out_port and match_slot are all zero.
// The receiver cannot stall: a result is valid only in its done cycle.
// The user must write the active_entries count through cfg_we and cfg_data
// only while idle; the block does not enforce it. Reset clears the count, busy
// and token valid bits; entries hold garbage until loaded and need no clearing.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_match #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               command,
  input  logic [lpm_pkg::INDEX_W-1:0]        entry_index,
  input  logic [lpm_pkg::ADDR_W-1:0]         route_prefix,
  input  logic [lpm_pkg::ADDR_W-1:0]         route_mask,
  input  logic [lpm_pkg::ADDR_W-1:0]         route_next_hop,
  input  logic [lpm_pkg::PORT_W-1:0]         route_port,
  input  logic [lpm_pkg::ADDR_W-1:0]         dest_addr,
  input  logic                               cfg_we,
  input  logic [lpm_pkg::COUNT_W-1:0]        cfg_data,
  output logic                               done,
  output logic                               found,
  output logic [lpm_pkg::ADDR_W-1:0]         hop_addr,
  output logic [lpm_pkg::PORT_W-1:0]         out_port,
  output logic [lpm_pkg::INDEX_W-1:0]        match_slot
);

  logic [lpm_pkg::COUNT_W-1:0] active_count;
  logic                        busy_next;
  logic                        accept;
  logic                        lookup_go;
  logic                        tail_in;
  lpm_pkg::load_t              load_bus;
  lpm_pkg::token_t             launch_tok;

  logic            chain_valid [TABLE_DEPTH];
  lpm_pkg::token_t chain_tok   [TABLE_DEPTH];

  assign accept    = start && !busy;
  assign lookup_go = accept && (command == lpm_pkg::CMD_LOOKUP);

  // Configuration register holding the number of active entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= '0;
    end else if (cfg_we) begin
      active_count <= cfg_data;
    end
  end

  // Entry write, broadcast to every cell; the mask rank is worked out once here.
  always_comb begin
    load_bus.we     = accept && (command == lpm_pkg::CMD_LOAD);
    load_bus.index  = entry_index;
    load_bus.prefix = route_prefix;
    load_bus.mask   = route_mask;
    load_bus.hop    = route_next_hop;
    load_bus.port   = route_port;
    load_bus.rank   = lpm_pkg::lead_ones(route_mask);
  end

  // A fresh token starts with no match and zero result fields.
  always_comb begin
    launch_tok      = '0;
    launch_tok.dest = dest_addr;
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      lpm_cell #(
        .CELL_INDEX(k)
      ) u_cell (
        .clk          (clk),
        .rst          (rst),
        .load         (load_bus),
        .active_count (active_count),
        .tok_in_valid (lookup_go),
        .tok_in       (launch_tok),
        .tok_out_valid(chain_valid[k]),
        .tok_out      (chain_tok[k])
      );
    end else begin : g_body
      lpm_cell #(
        .CELL_INDEX(k)
      ) u_cell (
        .clk          (clk),
        .rst          (rst),
        .load         (load_bus),
        .active_count (active_count),
        .tok_in_valid (chain_valid[k-1]),
        .tok_in       (chain_tok[k-1]),
        .tok_out_valid(chain_valid[k]),
        .tok_out      (chain_tok[k])
      );
    end
  end

  // The token entering the last cell means the result shows next cycle.
  if (TABLE_DEPTH > 1) begin : g_tail
    assign tail_in = chain_valid[TABLE_DEPTH-2];
  end else begin : g_tail_single
    assign tail_in = 1'b1;
  end

  always_comb begin
    busy_next = busy;
    if (lookup_go) begin
      busy_next = (TABLE_DEPTH > 1);
    end else if (tail_in) begin
      busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= busy_next;
    end
  end

  // The last cell's registered token is the result.
  assign done       = chain_valid[TABLE_DEPTH-1];
  assign found      = chain_tok[TABLE_DEPTH-1].hit;
  assign hop_addr   = chain_tok[TABLE_DEPTH-1].hop;
  assign out_port   = chain_tok[TABLE_DEPTH-1].port;
  assign match_slot = chain_tok[TABLE_DEPTH-1].slot[lpm_pkg::INDEX_W-1:0];

  // A result never coincides with a lookup still in flight.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result issued while busy");

  // A miss must report all-zero result fields.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (hop_addr == '0 && out_port == '0 && match_slot == '0))
    else $error("miss with nonzero result fields");

  // An accepted lookup holds off further items until its result.
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    lookup_go |=> (busy || (TABLE_DEPTH == 1)))
    else $error("busy not raised after lookup accept");

  // A load never produces a result or raises busy.
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (load_bus.we && !busy) |=> !busy)
    else $error("load raised busy");

endmodule

@@ hdl/lpm_cell.sv @@
// ----------------------------------------------------------------------------
// lpm_cell: one routing entry and one stage of the lookup chain
// Stores one entry; a passing token takes it as best match if the cell is
// active, it matches and the token has none yet or a strictly shorter one.
// ----------------------------------------------------------------------------
module lpm_cell #(
  parameter int unsigned CELL_INDEX = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lpm_pkg::load_t                load,
  input  logic [lpm_pkg::COUNT_W-1:0]   active_count,
  input  logic                          tok_in_valid,
  input  lpm_pkg::token_t               tok_in,
  output logic                          tok_out_valid,
  output lpm_pkg::token_t               tok_out
);

  localparam logic [lpm_pkg::CMP_W-1:0]  CmpSlot = lpm_pkg::CMP_W'(CELL_INDEX);
  localparam logic [lpm_pkg::SLOT_W-1:0] SlotId  = lpm_pkg::SLOT_W'(CELL_INDEX);

  logic [lpm_pkg::ADDR_W-1:0] prefix;
  logic [lpm_pkg::ADDR_W-1:0] mask;
  logic [lpm_pkg::ADDR_W-1:0] hop;
  logic [lpm_pkg::PORT_W-1:0] port;
  logic [lpm_pkg::RANK_W-1:0] rank;

  logic            write_hit;
  logic            enabled;
  logic            take;
  lpm_pkg::token_t tok_next;

  assign write_hit = load.we &&
                     ({{(lpm_pkg::CMP_W - lpm_pkg::INDEX_W){1'b0}}, load.index} == CmpSlot);
  assign enabled   = {{(lpm_pkg::CMP_W - lpm_pkg::COUNT_W){1'b0}}, active_count} > CmpSlot;

  always_ff @(posedge clk) begin
    if (write_hit) begin
      prefix <= load.prefix;
      mask   <= load.mask;
      hop    <= load.hop;
      port   <= load.port;
      rank   <= load.rank;
    end
  end

  always_comb begin
    take     = enabled && ((tok_in.dest & mask) == prefix) &&
               (!tok_in.hit || (rank > tok_in.rank));
    tok_next = tok_in;
    if (take) begin
      tok_next.hit  = 1'b1;
      tok_next.rank = rank;
      tok_next.slot = SlotId;
      tok_next.hop  = hop;
      tok_next.port = port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

endmodule

@@ dv/ipv4_longest_prefix_match_tb.sv @@
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_match_tb: self-checking bench for the LPM routing table
// Drives load and lookup items through the start/busy handshake, keeps its
// own copy of the routing table and active count, and predicts the winning
// route for each lookup by scanning every active entry. Each done strobe is
// compared field by field against the oldest prediction. A short directed
// table comes first, then table fills and mixed random traffic under three
// sender idle rates and a range of active counts, saturated values included.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_match_tb;

  localparam int unsigned DEPTH       = 256;
  // A lookup walks the whole cell chain, so the run time is set mainly by
  // the roughly 1400 lookups. The limit leaves several times the slowest
  // correct run as headroom.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned SEGMENTS    = 4;    // active-count settings per idle rate
  localparam int unsigned SEG_ITEMS   = 145;  // items between two settings
  localparam int unsigned DIR_ROWS    = 24;

  // One lookup result as it appears on the output ports.
  typedef struct packed {
    logic                        found;
    logic [lpm_pkg::ADDR_W-1:0]  hop;
    logic [lpm_pkg::PORT_W-1:0]  port;
    logic [lpm_pkg::INDEX_W-1:0] slot;
  } route_result_t;

  // One input item, every field on its own port.
  typedef struct packed {
    logic                        cmd;
    logic [lpm_pkg::INDEX_W-1:0] idx;
    logic [lpm_pkg::ADDR_W-1:0]  prefix;
    logic [lpm_pkg::ADDR_W-1:0]  mask;
    logic [lpm_pkg::ADDR_W-1:0]  hop;
    logic [lpm_pkg::PORT_W-1:0]  port;
    logic [lpm_pkg::ADDR_W-1:0]  dest;
  } lpm_item_t;

  // Directed rows: a register write, a load, a lookup checked against the
  // predictor, or a lookup whose answer is obvious and typed in.
  typedef enum logic [1:0] {ROW_CONFIG, ROW_LOAD, ROW_LOOKUP, ROW_LOOKUP_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [lpm_pkg::INDEX_W-1:0] idx;
    logic [lpm_pkg::ADDR_W-1:0]  prefix;
    logic [lpm_pkg::ADDR_W-1:0]  mask;
    logic [lpm_pkg::ADDR_W-1:0]  hop;
    logic [lpm_pkg::PORT_W-1:0]  port;
    logic [lpm_pkg::ADDR_W-1:0]  dest;
    logic [lpm_pkg::COUNT_W-1:0] count;
    route_result_t               known;
  } dir_row_t;

  localparam route_result_t NO_ROUTE = '{1'b0, 32'h0, 4'h0, 8'h0};

  // Slots 0..7 and 255 get loaded here; the active count never exceeds 8, so
  // no lookup ever reaches a slot that was never written.
  dir_row_t dir_table [DIR_ROWS] = '{
    // Straight out of reset nothing is active, so every lookup misses. The
    // load fields carry junk that a lookup must ignore.
    '{ROW_CONFIG, 8'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0, 9'd0, NO_ROUTE},
    '{ROW_LOOKUP_KNOWN, 8'hff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 4'hf,
      32'h00000000, 9'd0, NO_ROUTE},
    '{ROW_LOOKUP_KNOWN, 8'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'hffffffff, 9'd0, NO_ROUTE},
    // Default route, two nested networks, a host route, a tie with slot 1,
    // a non-contiguous mask, a prefix that can never match, and the extremes.
    '{ROW_LOAD, 8'd0, 32'h00000000, 32'h00000000, 32'h01020304, 4'd1, 32'hffffffff,
      9'd0, NO_ROUTE},
    '{ROW_LOAD, 8'd1, 32'hc0a80000, 32'hffff0000, 32'h0a000001, 4'd3, 32'h0, 9'd0, NO_ROUTE},
    '{ROW_LOAD, 8'd2, 32'hc0a80100, 32'hffffff00, 32'h0a000002, 4'd5, 32'h0, 9'd0, NO_ROUTE},
    '{ROW_LOAD, 8'd3, 32'hffffffff, 32'hffffffff, 32'h00000000, 4'd0, 32'h0, 9'd0, NO_ROUTE},
    '{ROW_LOAD, 8'd4, 32'hc0a80000, 32'hffff0000, 32'h0a000004, 4'd4, 32'h0, 9'd0, NO_ROUTE},
    '{ROW_LOAD, 8'd5, 32'h0a000a00, 32'hff00ff00, 32'h0a000005, 4'd6, 32'h0, 9'd0, NO_ROUTE},
    '{ROW_LOAD, 8'd6, 32'h00000001, 32'hffffff00, 32'h0a000006, 4'd7, 32'h0, 9'd0, NO_ROUTE},
    '{ROW_LOAD, 8'hff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 4'hf, 32'h0, 9'd0, NO_ROUTE},
    '{ROW_LOAD, 8'd7, 32'h00000000, 32'h00000000, 32'h00000000, 4'd0, 32'h0, 9'd0, NO_ROUTE},
    // With one active slot only the default route can win.
    '{ROW_CONFIG, 8'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0, 9'd1, NO_ROUTE},
    '{ROW_LOOKUP, 8'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'hc0a80105, 9'd0, NO_ROUTE},
    '{ROW_CONFIG, 8'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0, 9'd8, NO_ROUTE},
    '{ROW_LOOKUP, 8'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'hc0a80105, 9'd0, NO_ROUTE},
    '{ROW_LOOKUP, 8'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'hc0a80205, 9'd0, NO_ROUTE},
    '{ROW_LOOKUP, 8'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'hffffffff, 9'd0, NO_ROUTE},
    '{ROW_LOOKUP, 8'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0a0b0a0c, 9'd0, NO_ROUTE},
    '{ROW_LOOKUP, 8'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h00000001, 9'd0, NO_ROUTE},
    '{ROW_LOOKUP, 8'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h00000000, 9'd0, NO_ROUTE},
    // Overwriting slot 0 with a one-bit route hands the default to slot 7.
    '{ROW_LOAD, 8'd0, 32'h80000000, 32'h80000000, 32'h0a000008, 4'd2, 32'h0, 9'd0, NO_ROUTE},
    '{ROW_LOOKUP, 8'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h00000001, 9'd0, NO_ROUTE},
    '{ROW_LOOKUP, 8'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h80000000, 9'd0, NO_ROUTE}
  };

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic                        command;
  logic [lpm_pkg::INDEX_W-1:0] entry_index;
  logic [lpm_pkg::ADDR_W-1:0]  route_prefix;
  logic [lpm_pkg::ADDR_W-1:0]  route_mask;
  logic [lpm_pkg::ADDR_W-1:0]  route_next_hop;
  logic [lpm_pkg::PORT_W-1:0]  route_port;
  logic [lpm_pkg::ADDR_W-1:0]  dest_addr;
  logic                        cfg_we;
  logic [lpm_pkg::COUNT_W-1:0] cfg_data;
  logic                        done;
  logic                        found;
  logic [lpm_pkg::ADDR_W-1:0]  hop_addr;
  logic [lpm_pkg::PORT_W-1:0]  out_port;
  logic [lpm_pkg::INDEX_W-1:0] match_slot;

  // Shadow copy of the routing table and the active count.
  logic [lpm_pkg::ADDR_W-1:0]  prefix_tbl [DEPTH];
  logic [lpm_pkg::ADDR_W-1:0]  mask_tbl [DEPTH];
  logic [lpm_pkg::ADDR_W-1:0]  hop_tbl [DEPTH];
  logic [lpm_pkg::PORT_W-1:0]  port_tbl [DEPTH];
  logic [lpm_pkg::COUNT_W-1:0] active_count;

  // Lookups in flight, oldest first.
  route_result_t               expected_routes [$];

  // A few network bases that random prefixes are carved from, so that
  // routes nest and lookups see several candidates of different lengths.
  logic [lpm_pkg::ADDR_W-1:0]  bases [4];

  int unsigned idle_pct;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned hits_seen;
  int unsigned cycle_count;
  int unsigned idle_plan [3]  = '{33, 86, 0};
  int unsigned count_plan [6] = '{256, 511, 0, 1, 255, 257};

  ipv4_longest_prefix_match #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .entry_index   (entry_index),
    .route_prefix  (route_prefix),
    .route_mask    (route_mask),
    .route_next_hop(route_next_hop),
    .route_port    (route_port),
    .dest_addr     (dest_addr),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .done          (done),
    .found         (found),
    .hop_addr      (hop_addr),
    .out_port      (out_port),
    .match_slot    (match_slot)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Route length is the run of ones from the top bit; any lower ones in a
  // non-contiguous mask still take part in the match but not in the rank.
  function automatic int unsigned mask_rank(input logic [lpm_pkg::ADDR_W-1:0] m);
    int unsigned n;
    n = 0;
    while (n < lpm_pkg::ADDR_W && m[lpm_pkg::ADDR_W-1-n]) n++;
    return n;
  endfunction

  // Scans the active slots in order; a later slot only wins with a strictly
  // longer route, so ties stay with the lowest slot.
  function automatic route_result_t best_route(input logic [lpm_pkg::ADDR_W-1:0] dest);
    route_result_t r;
    int unsigned   lim;
    int unsigned   best_len;
    int unsigned   len;
    r = NO_ROUTE;
    best_len = 0;
    lim = (active_count > DEPTH) ? DEPTH : active_count;
    for (int unsigned i = 0; i < lim; i++) begin
      if ((dest & mask_tbl[i]) == prefix_tbl[i]) begin
        len = mask_rank(mask_tbl[i]);
        if (!r.found || len > best_len) begin
          best_len = len;
          r = '{1'b1, hop_tbl[i], port_tbl[i], lpm_pkg::INDEX_W'(i)};
        end
      end
    end
    return r;
  endfunction

  // A load updates the shadow table; a lookup queues its predicted route.
  task automatic record_item(input lpm_item_t it);
    if (it.cmd == lpm_pkg::CMD_LOAD) begin
      prefix_tbl[it.idx] = it.prefix;
      mask_tbl[it.idx]   = it.mask;
      hop_tbl[it.idx]    = it.hop;
      port_tbl[it.idx]   = it.port;
    end else begin
      expected_routes.push_back(best_route(it.dest));
    end
  endtask

  // Presents one item until the block takes it. Start is decided afresh at
  // every falling edge, so idle cycles land anywhere in a lookup, including
  // the done cycle where a new item could have been taken.
  task automatic issue(input lpm_item_t it);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      start          = ($urandom_range(99) >= idle_pct);
      command        = it.cmd;
      entry_index    = it.idx;
      route_prefix   = it.prefix;
      route_mask     = it.mask;
      route_next_hop = it.hop;
      route_port     = it.port;
      dest_addr      = it.dest;
      @(posedge clk);
      taken = start && !busy;
    end
    items_sent++;
  endtask

  // Holds the sender off until every lookup has answered. Loads finish in
  // their accept edge, so they need no wait of their own.
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (expected_routes.size() != 0 || busy) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_active(input int unsigned n);
    wait_drained();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = lpm_pkg::COUNT_W'(n);
    @(posedge clk);
    active_count = lpm_pkg::COUNT_W'(n);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly contiguous masks of every length with prefixes taken from a base;
  // one in ten gets a random mask, and one in ten a random prefix, whose stray
  // host bits usually keep it from ever matching.
  function automatic lpm_item_t random_route();
    lpm_item_t   it;
    int unsigned len;
    len       = $urandom_range(lpm_pkg::ADDR_W);
    it.cmd    = lpm_pkg::CMD_LOAD;
    it.idx    = lpm_pkg::INDEX_W'($urandom_range(DEPTH - 1));
    if ($urandom_range(9) == 0) it.mask = $urandom;
    else it.mask = (len == 0) ? '0 :
                   ({lpm_pkg::ADDR_W{1'b1}} << (lpm_pkg::ADDR_W - len));
    if ($urandom_range(9) == 0) it.prefix = $urandom;
    else it.prefix = bases[$urandom_range(3)] & it.mask;
    it.hop    = $urandom;
    it.port   = lpm_pkg::PORT_W'($urandom);
    it.dest   = $urandom;
    return it;
  endfunction

  // Most destinations fall inside an active route, some near a base, and
  // the rest anywhere. Load fields carry junk the block must ignore.
  function automatic lpm_item_t random_lookup();
    lpm_item_t   it;
    int unsigned lim;
    int unsigned pick;
    int unsigned s;
    it        = random_route();
    it.cmd    = lpm_pkg::CMD_LOOKUP;
    lim       = (active_count > DEPTH) ? DEPTH : active_count;
    pick      = $urandom_range(99);
    if (lim != 0 && pick < 70) begin
      s = $urandom_range(lim - 1);
      it.dest = prefix_tbl[s] | ($urandom & ~mask_tbl[s]);
    end else if (pick < 85) begin
      it.dest = bases[$urandom_range(3)] ^ ($urandom >> $urandom_range(lpm_pkg::ADDR_W - 1));
    end else begin
      it.dest = $urandom;
    end
    return it;
  endfunction

  // Results cannot be held off, so every done strobe is checked on the spot.
  always @(posedge clk) begin : check_results
    route_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_routes.size() == 0) begin
        $error("result with no lookup pending: found %0d, match_slot %0d", found, match_slot);
        fail_count++;
      end else begin
        want = expected_routes.pop_front();
        if (found) hits_seen++;
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          fail_count++;
        end
        if (hop_addr !== want.hop) begin
          $error("hop_addr: expected %h, got %h", want.hop, hop_addr);
          fail_count++;
        end
        if (out_port !== want.port) begin
          $error("out_port: expected %0d, got %0d", want.port, out_port);
          fail_count++;
        end
        if (match_slot !== want.slot) begin
          $error("match_slot: expected %0d, got %0d", want.slot, match_slot);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    lpm_item_t   it;
    int unsigned n;
    rst            = 1'b1;
    start          = 1'b0;
    command        = lpm_pkg::CMD_LOAD;
    entry_index    = '0;
    route_prefix   = '0;
    route_mask     = '0;
    route_next_hop = '0;
    route_port     = '0;
    dest_addr      = '0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    active_count   = '0;
    fail_count     = 0;
    items_sent     = 0;
    results_seen   = 0;
    hits_seen      = 0;
    idle_pct       = idle_plan[0];
    foreach (bases[i]) bases[i] = $urandom;

    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed table.
    foreach (dir_table[r]) begin
      it = '{(dir_table[r].kind == ROW_LOAD) ? lpm_pkg::CMD_LOAD : lpm_pkg::CMD_LOOKUP,
             dir_table[r].idx, dir_table[r].prefix, dir_table[r].mask, dir_table[r].hop,
             dir_table[r].port, dir_table[r].dest};
      case (dir_table[r].kind)
        ROW_CONFIG: begin
          write_active(dir_table[r].count);
        end
        ROW_LOOKUP_KNOWN: begin
          issue(it);
          expected_routes.push_back(dir_table[r].known);
        end
        default: begin
          issue(it);
          record_item(it);
        end
      endcase
    end

    // Fill every slot so that any active count, saturated ones included,
    // only ever reads loaded entries.
    for (int unsigned i = 0; i < DEPTH; i++) begin
      it = random_route();
      it.idx = lpm_pkg::INDEX_W'(i);
      issue(it);
      record_item(it);
    end

    // Mixed traffic: one load in five reshapes the table under live lookups.
    // The first settings hit the count extremes, the rest are random.
    for (int unsigned p = 0; p < 3; p++) begin
      idle_pct = idle_plan[p];
      for (int unsigned s = 0; s < SEGMENTS; s++) begin
        n = p * SEGMENTS + s;
        write_active((n < 6) ? count_plan[n] : $urandom_range(1, DEPTH));
        for (int unsigned k = 0; k < SEG_ITEMS; k++) begin
          if ($urandom_range(99) == 0) wait_drained();
          it = ($urandom_range(4) == 0) ? random_route() : random_lookup();
          issue(it);
          record_item(it);
        end
      end
    end

    // Let the last lookup come home, then watch one more chain length for
    // stray strobes.
    wait_drained();
    repeat (DEPTH + 8) @(negedge clk);

    $display("Ran %0d items: %0d lookups answered, %0d of them routed, %0d unrouted.",
             items_sent, results_seen, hits_seen, results_seen - hits_seen);
    $display("Table fully loaded; active counts from empty to saturated at three idle rates.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
